FILE: rtl/nearest_neighbor_image_scaler_unit_defines.svh
// assertion macros used by the property file
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_UNIT_DEFINES_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define NNIS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define NNIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/nnis_pkg.sv
`default_nettype none

package nnis_pkg;

    typedef enum logic
    {
        REQ_LOAD = 1'b0,
        REQ_EMIT = 1'b1
    } req_kind_t;

    localparam logic [2:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_COMPONENTS = 3'd4;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed
    {
        logic [8:0]  src_width;
        logic [8:0]  src_height;
        logic [12:0] dst_width;
        logic [12:0] dst_height;
        logic [2:0]  components;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        src_width:  9'd1,
        src_height: 9'd1,
        dst_width:  13'd1,
        dst_height: 13'd1,
        components: 3'd4
    };

    // zero acts as one, values above the limit act as the limit
    function automatic logic [12:0] clamp_dim(input logic [12:0] v, input logic [16:0] maxv);
        logic [12:0] r;
        if (v == 13'd0)
        begin
            r = 13'd1;
        end
        else if ({4'b0000, v} > maxv)
        begin
            r = maxv[12:0];
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [2:0] clamp_comps(input logic [2:0] v);
        logic [2:0] r;
        if (v == 3'd0)
        begin
            r = 3'd1;
        end
        else if (v > 3'd4)
        begin
            r = 3'd4;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/nnis_front.sv
`default_nettype none

module nnis_front
    import nnis_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int MAX_DST_DIM    = 4096,
    parameter int AW             = 16,
    parameter int TW             = 17,
    parameter int CW             = 12,
    parameter int PW             = 48
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire cfg_t            cfg,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic            req_type,
    input  wire logic [7:0]      in_c0,
    input  wire logic [7:0]      in_c1,
    input  wire logic [7:0]      in_c2,
    input  wire logic [7:0]      in_c3,
    input  wire logic            q_full,
    output logic                 push,
    output logic [PW+1:0]        push_entry
);

    logic [12:0]   sw_full;
    logic [12:0]   sh_full;
    logic [8:0]    sw;
    logic [8:0]    sh;
    logic [12:0]   dw;
    logic [12:0]   dh;
    logic [17:0]   total_prod;
    logic [TW-1:0] total;
    logic [AW-1:0] load_index_reg;
    logic [AW-1:0] load_index_next;
    logic [AW-1:0] ld_idx;
    logic [TW-1:0] ld_inc;
    logic [CW-1:0] dest_col_reg;
    logic [CW-1:0] dest_col_next;
    logic [CW-1:0] dest_row_reg;
    logic [CW-1:0] dest_row_next;
    logic [CW-1:0] col_cur;
    logic [CW-1:0] row_cur;
    logic [12:0]   col_inc;
    logic [12:0]   row_inc;
    logic          em_last;
    req_kind_t     kind;
    logic          accept;

    assign sw_full = clamp_dim(13'(cfg.src_width), 17'(MAX_SRC_WIDTH));
    assign sh_full = clamp_dim(13'(cfg.src_height), 17'(MAX_SRC_HEIGHT));
    assign sw      = sw_full[8:0];
    assign sh      = sh_full[8:0];
    assign dw      = clamp_dim(cfg.dst_width, 17'(MAX_DST_DIM));
    assign dh      = clamp_dim(cfg.dst_height, 17'(MAX_DST_DIM));

    assign total_prod = 18'(sw) * 18'(sh);
    assign total      = TW'(total_prod);

    assign kind     = req_kind_t'(req_type);
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept;

    // load address: wraps after the last source pixel
    assign ld_idx = (TW'(load_index_reg) < total) ? load_index_reg : '0;
    assign ld_inc = TW'(ld_idx) + TW'(1);
    assign load_index_next = (ld_inc >= total) ? '0 : ld_inc[AW-1:0];

    // destination raster position
    assign col_cur = (13'(dest_col_reg) >= dw) ? '0 : dest_col_reg;
    assign row_cur = (13'(dest_row_reg) >= dh) ? '0 : dest_row_reg;
    assign em_last = (13'(col_cur) == dw - 13'd1) && (13'(row_cur) == dh - 13'd1);
    assign col_inc = 13'(col_cur) + 13'd1;
    assign row_inc = 13'(row_cur) + 13'd1;

    always_comb
    begin
        if (col_inc >= dw)
        begin
            dest_col_next = '0;
            dest_row_next = (row_inc >= dh) ? '0 : row_inc[CW-1:0];
        end
        else
        begin
            dest_col_next = col_inc[CW-1:0];
            dest_row_next = row_cur;
        end
    end

    always_comb
    begin
        if (kind == REQ_LOAD)
        begin
            push_entry = {kind, 1'b0, PW'({ld_idx, in_c3, in_c2, in_c1, in_c0})};
        end
        else
        begin
            push_entry = {kind, em_last, PW'({col_cur, row_cur})};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_index_reg <= '0;
            dest_col_reg   <= '0;
            dest_row_reg   <= '0;
        end
        else if (accept)
        begin
            if (kind == REQ_LOAD)
            begin
                load_index_reg <= load_index_next;
            end
            else
            begin
                dest_col_reg <= dest_col_next;
                dest_row_reg <= dest_row_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/nnis_fifo.sv
`default_nettype none

module nnis_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  full,
    output logic                  not_empty
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg;
    logic [PTRW-1:0]  rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;

    assign full      = (count_reg == CNTW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTRW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTRW'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + CNTW'(1);
                2'b01:   count_reg <= count_reg - CNTW'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/nnis_back.sv
`default_nettype none

module nnis_back
    import nnis_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int MAX_DST_DIM    = 4096,
    parameter int AW             = 16,
    parameter int DEPTH          = 65536,
    parameter int CW             = 12,
    parameter int PW             = 48,
    parameter int ITER           = 8
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire cfg_t            cfg,
    input  wire logic            head_valid,
    input  wire logic [PW+1:0]   head_entry,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic [7:0]           out_c0,
    output logic [7:0]           out_c1,
    output logic [7:0]           out_c2,
    output logic [7:0]           out_c3,
    output logic                 frame_last
);

    localparam int XW  = CW + 9;
    localparam int DVW = 13 + ITER - 1;
    localparam int EW  = (XW > DVW) ? XW : DVW;
    localparam int STW = (ITER > 1) ? $clog2(ITER) : 1;
    localparam int IPW = ITER + 9;

    typedef enum logic [4:0]
    {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_IDX  = 5'b00100,
        S_RD   = 5'b01000,
        S_PUT  = 5'b10000
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [12:0]     sw_full;
    logic [12:0]     sh_full;
    logic [8:0]      sw;
    logic [8:0]      sh;
    logic [12:0]     dw;
    logic [12:0]     dh;
    logic [2:0]      nc;
    req_kind_t       head_kind;
    logic            head_last;
    logic [PW-1:0]   head_payload;
    logic [AW-1:0]   ld_addr;
    logic [31:0]     ld_data;
    logic [CW-1:0]   em_col;
    logic [CW-1:0]   em_row;
    logic [XW-1:0]   prod_x;
    logic [XW-1:0]   prod_y;
    logic            ge_x;
    logic            ge_y;
    logic [STW-1:0]  step_reg;
    logic [XW-1:0]   rem_x_reg;
    logic [XW-1:0]   rem_y_reg;
    logic [DVW-1:0]  div_x_reg;
    logic [DVW-1:0]  div_y_reg;
    logic [ITER-1:0] qx_reg;
    logic [ITER-1:0] qy_reg;
    logic            last_reg;
    logic [IPW-1:0]  idx_sum;
    logic [AW-1:0]   idx_reg;
    logic [31:0]     mem [DEPTH];
    logic [31:0]     rd_data_reg;
    logic [31:0]     masked;
    logic            out_valid_reg;
    logic [31:0]     out_data_reg;
    logic            out_last_reg;
    logic            out_load;
    logic            pop_emit;
    logic            pop_load;

    assign sw_full = clamp_dim(13'(cfg.src_width), 17'(MAX_SRC_WIDTH));
    assign sh_full = clamp_dim(13'(cfg.src_height), 17'(MAX_SRC_HEIGHT));
    assign sw      = sw_full[8:0];
    assign sh      = sh_full[8:0];
    assign dw      = clamp_dim(cfg.dst_width, 17'(MAX_DST_DIM));
    assign dh      = clamp_dim(cfg.dst_height, 17'(MAX_DST_DIM));
    assign nc      = clamp_comps(cfg.components);

    assign head_kind    = req_kind_t'(head_entry[PW+1]);
    assign head_last    = head_entry[PW];
    assign head_payload = head_entry[PW-1:0];
    assign ld_addr      = head_payload[AW+31:32];
    assign ld_data      = head_payload[31:0];
    assign em_col       = head_payload[2*CW-1:CW];
    assign em_row       = head_payload[CW-1:0];

    assign pop      = head_valid && (state_reg == S_IDLE);
    assign pop_emit = pop && (head_kind == REQ_EMIT);
    assign pop_load = pop && (head_kind == REQ_LOAD);
    assign out_load = (state_reg == S_PUT) && (!out_valid_reg || !out_stall);

    // scaled coordinates: col * src_w and row * src_h
    assign prod_x = XW'(em_col) * XW'(sw);
    assign prod_y = XW'(em_row) * XW'(sh);

    // one quotient bit per cycle
    assign ge_x = EW'(rem_x_reg) >= EW'(div_x_reg);
    assign ge_y = EW'(rem_y_reg) >= EW'(div_y_reg);

    assign idx_sum = IPW'(qy_reg) * IPW'(sw) + IPW'(qx_reg);

    assign masked[7:0]   = rd_data_reg[7:0];
    assign masked[15:8]  = (nc > 3'd1) ? rd_data_reg[15:8] : 8'h00;
    assign masked[23:16] = (nc > 3'd2) ? rd_data_reg[23:16] : 8'h00;
    assign masked[31:24] = (nc > 3'd3) ? rd_data_reg[31:24] : 8'h00;

    assign out_valid  = out_valid_reg;
    assign out_c0     = out_data_reg[7:0];
    assign out_c1     = out_data_reg[15:8];
    assign out_c2     = out_data_reg[23:16];
    assign out_c3     = out_data_reg[31:24];
    assign frame_last = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_emit)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = S_IDX;
                end
            end
            S_IDX:
            begin
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_PUT;
            end
            S_PUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop_emit)
            begin
                step_reg <= STW'(ITER - 1);
            end
            else if ((state_reg == S_DIV) && (step_reg != '0))
            begin
                step_reg <= step_reg - STW'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_emit)
        begin
            rem_x_reg <= prod_x;
            rem_y_reg <= prod_y;
            div_x_reg <= DVW'(dw) << (ITER - 1);
            div_y_reg <= DVW'(dh) << (ITER - 1);
            qx_reg    <= '0;
            qy_reg    <= '0;
            last_reg  <= head_last;
        end
        else if (state_reg == S_DIV)
        begin
            if (ge_x)
            begin
                rem_x_reg <= XW'(EW'(rem_x_reg) - EW'(div_x_reg));
            end
            if (ge_y)
            begin
                rem_y_reg <= XW'(EW'(rem_y_reg) - EW'(div_y_reg));
            end
            div_x_reg <= div_x_reg >> 1;
            div_y_reg <= div_y_reg >> 1;
            qx_reg    <= ITER'({qx_reg, ge_x});
            qy_reg    <= ITER'({qy_reg, ge_y});
        end
        if (state_reg == S_IDX)
        begin
            idx_reg <= AW'(idx_sum);
        end
        if (out_load)
        begin
            out_data_reg <= masked;
            out_last_reg <= last_reg;
        end
    end

    // frame store
    always_ff @(posedge clk)
    begin
        if (pop_load)
        begin
            mem[ld_addr] <= ld_data;
        end
        if (state_reg == S_RD)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/nearest_neighbor_image_scaler_unit.sv
`default_nettype none

// Nearest-neighbor image scaler. A load request writes the next source pixel (four bytes)
// into the frame store in raster order, wrapping after src_width * src_height pixels; an
// emit request returns the next destination pixel in raster order, sampled from source
// (floor(x * src_w / dst_w), floor(y * src_h / dst_h)), with components beyond the
// configured count forced to zero and frame_last set on the final pixel. The front end
// takes one request per cycle into a four-entry queue and in_stall rises only when that
// queue is full. The back end retires a load as soon as it pops it; an emit passes through
// the radix-2 coordinate divider, which makes one quotient bit per cycle for both axes at
// once, then the address multiply and the frame store read, and the back end pops no new
// request until that emit's result has been loaded into the output register.
// The frame store is not cleared: an entry reads as garbage until it has been loaded.
// Configuration registers are written through cfg_we / cfg_index / cfg_data and must
// only change while no request is in flight.
module nearest_neighbor_image_scaler_unit
    import nnis_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int MAX_DST_DIM    = 4096
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic [7:0]  in_c0,
    input  wire logic [7:0]  in_c1,
    input  wire logic [7:0]  in_c2,
    input  wire logic [7:0]  in_c3,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_c0,
    output logic [7:0]       out_c1,
    output logic [7:0]       out_c2,
    output logic [7:0]       out_c3,
    output logic             frame_last
);

    localparam int SRC_W_LIM = (MAX_SRC_WIDTH < 511) ? MAX_SRC_WIDTH : 511;
    localparam int SRC_H_LIM = (MAX_SRC_HEIGHT < 511) ? MAX_SRC_HEIGHT : 511;
    localparam int DST_LIM   = (MAX_DST_DIM < 8191) ? MAX_DST_DIM : 8191;
    localparam int DEPTH     = SRC_W_LIM * SRC_H_LIM;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW        = $clog2(DEPTH + 1);
    localparam int CW        = (DST_LIM > 1) ? $clog2(DST_LIM) : 1;
    localparam int SXW       = (SRC_W_LIM > 1) ? $clog2(SRC_W_LIM) : 1;
    localparam int SYW       = (SRC_H_LIM > 1) ? $clog2(SRC_H_LIM) : 1;
    localparam int ITER      = (SXW > SYW) ? SXW : SYW;
    localparam int PW        = ((AW + 32) > (2 * CW)) ? (AW + 32) : (2 * CW);

    cfg_t          cfg_reg;
    logic          push;
    logic [PW+1:0] push_entry;
    logic          pop;
    logic [PW+1:0] head_entry;
    logic          q_full;
    logic          head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SRC_WIDTH:  cfg_reg.src_width  <= cfg_data[8:0];
                CFG_SRC_HEIGHT: cfg_reg.src_height <= cfg_data[8:0];
                CFG_DST_WIDTH:  cfg_reg.dst_width  <= cfg_data;
                CFG_DST_HEIGHT: cfg_reg.dst_height <= cfg_data;
                CFG_COMPONENTS: cfg_reg.components <= cfg_data[2:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    nnis_front
    #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .MAX_DST_DIM    (MAX_DST_DIM),
        .AW             (AW),
        .TW             (TW),
        .CW             (CW),
        .PW             (PW)
    )
    u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .in_c0      (in_c0),
        .in_c1      (in_c1),
        .in_c2      (in_c2),
        .in_c3      (in_c3),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    nnis_fifo
    #(
        .WIDTH (PW + 2),
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .pop       (pop),
        .pop_data  (head_entry),
        .full      (q_full),
        .not_empty (head_valid)
    );

    nnis_back
    #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .MAX_DST_DIM    (MAX_DST_DIM),
        .AW             (AW),
        .DEPTH          (DEPTH),
        .CW             (CW),
        .PW             (PW),
        .ITER           (ITER)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_c0     (out_c0),
        .out_c1     (out_c1),
        .out_c2     (out_c2),
        .out_c3     (out_c3),
        .frame_last (frame_last)
    );

endmodule

`default_nettype wire

FILE: rtl/nnis_props.sv
`default_nettype none

`include "nearest_neighbor_image_scaler_unit_defines.svh"

module nnis_props
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [7:0]  out_c0,
    input wire logic [7:0]  out_c1,
    input wire logic [7:0]  out_c2,
    input wire logic [7:0]  out_c3,
    input wire logic        frame_last
);

    logic [32:0] out_word;

    assign out_word = {out_c3, out_c2, out_c1, out_c0, frame_last};

    // a stalled result stays up
    `NNIS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

    // a stalled result does not change
    `NNIS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_word), "stalled result changed")

    // queue only fills through an accepted request
    `NNIS_ASSERT_IMPL(a_stall_push, $rose(in_stall), $past(in_valid) && !$past(in_stall), "stall rose without a request")

    // a result only leaves when it is taken
    `NNIS_ASSERT_IMPL(a_out_taken, $fell(out_valid), !$past(out_stall), "result vanished untaken")

endmodule

bind nearest_neighbor_image_scaler_unit nnis_props u_props (.*);

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import nnis_pkg::*;

    localparam int unsigned SRC_MAX      = 256;
    localparam int unsigned DST_MAX      = 4096;
    localparam int unsigned DRAIN_CYCLES = 30;
    localparam int unsigned RANDOM_ITEMS = 540;
    localparam int unsigned CYCLE_LIMIT  = 800000;

    typedef struct packed
    {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        logic       last;
    } scaled_pixel_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [2:0]  cfg_index  = CFG_SRC_WIDTH;
    logic [12:0] cfg_data   = '0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic        req_type   = REQ_LOAD;
    logic [7:0]  in_c0      = '0;
    logic [7:0]  in_c1      = '0;
    logic [7:0]  in_c2      = '0;
    logic [7:0]  in_c3      = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [7:0]  out_c0;
    logic [7:0]  out_c1;
    logic [7:0]  out_c2;
    logic [7:0]  out_c3;
    logic        frame_last;

    // predictor state
    logic [31:0]  pix_store [65536];
    int unsigned  load_ptr = 0;
    int unsigned  col_ptr  = 0;
    int unsigned  row_ptr  = 0;
    logic [8:0]   reg_src_w  = 9'd1;
    logic [8:0]   reg_src_h  = 9'd1;
    logic [12:0]  reg_dst_w  = 13'd1;
    logic [12:0]  reg_dst_h  = 13'd1;
    logic [2:0]   reg_comps  = 3'd4;

    scaled_pixel_t pending_pixels [$];

    int unsigned items_sent     = 0;
    int unsigned error_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    bit          tx_idle_on     = 1'b1;
    bit          rx_idle_on     = 1'b1;

    nearest_neighbor_image_scaler_unit u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .in_c0      (in_c0),
        .in_c1      (in_c1),
        .in_c2      (in_c2),
        .in_c3      (in_c3),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_c0     (out_c0),
        .out_c1     (out_c1),
        .out_c2     (out_c2),
        .out_c3     (out_c3),
        .frame_last (frame_last)
    );

    always #5 clk = ~clk;

    function automatic int unsigned eff_dim(input int unsigned raw, input int unsigned maxv);
        if (raw == 0)
        begin
            return 1;
        end
        return (raw > maxv) ? maxv : raw;
    endfunction

    function automatic int unsigned source_total();
        return eff_dim(reg_src_w, SRC_MAX) * eff_dim(reg_src_h, SRC_MAX);
    endfunction

    function automatic void predict_scaler(input req_kind_t kind,
                                           input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3);
        int unsigned   sw;
        int unsigned   sh;
        int unsigned   dw;
        int unsigned   dh;
        int unsigned   nc;
        int unsigned   total;
        int unsigned   idx;
        int unsigned   sx;
        int unsigned   sy;
        logic [31:0]   word;
        scaled_pixel_t px;
        sw    = eff_dim(reg_src_w, SRC_MAX);
        sh    = eff_dim(reg_src_h, SRC_MAX);
        dw    = eff_dim(reg_dst_w, DST_MAX);
        dh    = eff_dim(reg_dst_h, DST_MAX);
        nc    = eff_dim(reg_comps, 4);
        total = sw * sh;
        if (kind == REQ_LOAD)
        begin
            idx = (load_ptr < total) ? load_ptr : 0;
            pix_store[idx] = {b3, b2, b1, b0};
            idx++;
            load_ptr = (idx >= total) ? 0 : idx;
        end
        else
        begin
            // position restarts when the frame shrank under it
            if (col_ptr >= dw)
            begin
                col_ptr = 0;
            end
            if (row_ptr >= dh)
            begin
                row_ptr = 0;
            end
            sx   = (col_ptr * sw) / dw;
            sy   = (row_ptr * sh) / dh;
            idx  = sy * sw + sx;
            word = (idx < total) ? pix_store[idx] : 32'd0;
            px.c0   = word[7:0];
            px.c1   = (nc >= 2) ? word[15:8]  : 8'd0;
            px.c2   = (nc >= 3) ? word[23:16] : 8'd0;
            px.c3   = (nc >= 4) ? word[31:24] : 8'd0;
            px.last = (col_ptr == dw - 1) && (row_ptr == dh - 1);
            pending_pixels.push_back(px);
            col_ptr++;
            if (col_ptr >= dw)
            begin
                col_ptr = 0;
                row_ptr++;
                if (row_ptr >= dh)
                begin
                    row_ptr = 0;
                end
            end
        end
    endfunction

    task automatic send_req(input req_kind_t kind,
                            input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [7:0] b3);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        in_c0    <= b0;
        in_c1    <= b1;
        in_c2    <= b2;
        in_c3    <= b3;
        do @(posedge clk); while (in_stall !== 1'b0);
        predict_scaler(kind, b0, b1, b2, b3);
        items_sent++;
    endtask

    task automatic send_rand(input req_kind_t kind);
        send_req(kind, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_pixels.size() != 0);
    endtask

    // loads may still be in flight after the last result
    task automatic settle_idle();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [12:0] sw, input logic [12:0] sh,
                              input logic [12:0] dw, input logic [12:0] dh,
                              input logic [12:0] nc);
        logic [2:0]  idx [5];
        logic [12:0] val [5];
        idx = '{CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_DST_WIDTH, CFG_DST_HEIGHT, CFG_COMPONENTS};
        val = '{sw, sh, dw, dh, nc};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            case (idx[i])
                CFG_SRC_WIDTH:  reg_src_w = val[i][8:0];
                CFG_SRC_HEIGHT: reg_src_h = val[i][8:0];
                CFG_DST_WIDTH:  reg_dst_w = val[i];
                CFG_DST_HEIGHT: reg_dst_h = val[i];
                CFG_COMPONENTS: reg_comps = val[i][2:0];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    // fill the whole source, then a random mix of loads and emits
    task automatic run_phase(input logic [12:0] sw, input logic [12:0] sh,
                             input logic [12:0] dw, input logic [12:0] dh,
                             input logic [12:0] nc, input int unsigned n_mix);
        int unsigned n_load;
        settle_idle();
        set_config(sw, sh, dw, dh, nc);
        n_load = source_total() + $urandom_range(0, 3);
        repeat (n_load) send_rand(REQ_LOAD);
        repeat (n_mix)
        begin
            if ($urandom_range(0, 99) < 3)
            begin
                wait_for_results();
            end
            send_rand(req_kind_t'(($urandom_range(0, 9) < 7) ? REQ_EMIT : REQ_LOAD));
        end
    endtask

    task automatic test_reset_defaults();
        send_req(REQ_LOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_req(REQ_EMIT, 8'h00, 8'h00, 8'h00, 8'h00);
        send_req(REQ_LOAD, 8'h00, 8'h00, 8'h00, 8'h00);
        // one pixel source: the index wraps at once
        send_req(REQ_LOAD, 8'hA5, 8'h5A, 8'h0F, 8'hF0);
        send_req(REQ_EMIT, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_req(REQ_EMIT, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_component_counts();
        settle_idle();
        set_config(13'd2, 13'd1, 13'd2, 13'd1, 13'd0);
        send_rand(REQ_LOAD);
        send_rand(REQ_LOAD);
        send_rand(REQ_EMIT);
        send_rand(REQ_EMIT);
        settle_idle();
        set_config(13'd2, 13'd1, 13'd2, 13'd1, 13'd3);
        send_rand(REQ_EMIT);
        send_rand(REQ_EMIT);
        settle_idle();
        set_config(13'd2, 13'd1, 13'd2, 13'd1, 13'd7);
        send_rand(REQ_EMIT);
        send_rand(REQ_EMIT);
    endtask

    task automatic test_frame_resize();
        settle_idle();
        set_config(13'd3, 13'd1, 13'd3, 13'd2, 13'd4);
        repeat (3) send_rand(REQ_LOAD);
        repeat (4) send_rand(REQ_EMIT);
        repeat (2) send_rand(REQ_LOAD);
        // load index and position now lie beyond the new sizes
        settle_idle();
        set_config(13'd1, 13'd1, 13'd1, 13'd1, 13'd4);
        send_rand(REQ_LOAD);
        send_rand(REQ_EMIT);
    endtask

    task automatic test_extreme_sizes();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_phase(13'd256, 13'd1, 13'd4096, 13'd1, 13'd4, 60);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        run_phase(13'd1, 13'd511, 13'd1, 13'h1FFF, 13'd3, 40);
        run_phase(13'h1FFF, 13'd0, 13'd3, 13'd0, 13'd7, 20);
        run_phase(13'd0, 13'h1100, 13'd4095, 13'd4096, 13'd1, 30);
    endtask

    function automatic logic [12:0] big_src_raw();
        case ($urandom_range(0, 3))
            0:       return 13'd256;
            1:       return 13'd511;
            2:       return 13'h1FFF;
            default: return 13'($urandom_range(0, 8191));
        endcase
    endfunction

    task automatic test_random_frames();
        int unsigned start;
        logic [12:0] sw;
        logic [12:0] sh;
        logic [12:0] dw;
        logic [12:0] dh;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            sw = 13'($urandom_range(0, 8));
            sh = 13'($urandom_range(0, 8));
            if ($urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    sw = big_src_raw();
                    sh = 13'($urandom_range(0, 2));
                end
                else
                begin
                    sh = big_src_raw();
                    sw = 13'($urandom_range(0, 2));
                end
            end
            dw = 13'($urandom_range(0, 12));
            dh = 13'($urandom_range(0, 12));
            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       dw = 13'd4096;
                    1:       dw = 13'h1FFF;
                    2:       dh = 13'($urandom_range(13, 8191));
                    default: dh = 13'd4096;
                endcase
            end
            run_phase(sw, sh, dw, dh, 13'($urandom_range(0, 7)), $urandom_range(20, 60));
        end
    endtask

    // result side
    initial
    begin : result_checker
        int            w;
        scaled_pixel_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            w = rx_idle_on ? $urandom_range(0, 10) : 0;
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            if (pending_pixels.size() == 0)
            begin
                error_count++;
                if (mismatch_count < 10)
                begin
                    $display("unexpected result: c0=%h c1=%h c2=%h c3=%h last=%b",
                             out_c0, out_c1, out_c2, out_c3, frame_last);
                end
                mismatch_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (out_c0 !== want.c0 || out_c1 !== want.c1 || out_c2 !== want.c2 ||
                    out_c3 !== want.c3 || frame_last !== want.last)
                begin
                    error_count++;
                    if (mismatch_count < 10)
                    begin
                        $display("mismatch: exp c0=%h c1=%h c2=%h c3=%h last=%b",
                                 want.c0, want.c1, want.c2, want.c3, want.last);
                        $display("          got c0=%h c1=%h c2=%h c3=%h last=%b",
                                 out_c0, out_c1, out_c2, out_c3, frame_last);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("nearest_neighbor_image_scaler_unit regression: fail");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_component_counts();
        test_frame_resize();
        test_extreme_sizes();
        test_random_frames();
        settle_idle();
        error_count += pending_pixels.size();
        if (error_count == 0)
        begin
            $display("nearest_neighbor_image_scaler_unit regression: pass");
        end
        else
        begin
            $display("nearest_neighbor_image_scaler_unit regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/nnis_pkg.sv
rtl/nnis_front.sv
rtl/nnis_fifo.sv
rtl/nnis_back.sv
rtl/nearest_neighbor_image_scaler_unit.sv
rtl/nnis_props.sv
bench/tb.sv
